// ----- hw/rtl/qrs_pkg.sv -----
package qrs_pkg;

	localparam int CoefW = 32;
	localparam int RootW = 48;
	localparam int DiscW = 66;
	localparam int SqrtW = 33;
	localparam int NumW  = 50;   // |numerator| magnitude, below 2^34, then scaled by 2^16
	localparam int DenW  = 33;   // |2a| or |b|
	localparam int QuoW  = 50;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DEGEN    = 2'd1,
		ST_SAT      = 2'd2,
		ST_RESERVED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MODE_REAL  = 2'd0,
		MODE_CPLX  = 2'd1,
		MODE_LIN   = 2'd2,
		MODE_DEGEN = 2'd3
	} mode_t;

	// per-item control that travels along the pipeline
	typedef struct packed {
		mode_t            mode;
		logic             neg_b;      // sign of -b numerator term
		logic [SqrtW-2:0] mag_b;      // |b| (32 bits)
		logic             den_neg;
		logic [DenW-1:0]  den_mag;
	} ctl_t;

endpackage

// ----- hw/rtl/quadratic_root_solver.sv -----
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready  | coef_quad, coef_lin, coef_const
// out     | output    | out_valid/out_ready| first_re, first_im, second_re, second_im, status
//
// one equation per cycle while the pipeline is not held by a full, unread output register
// the depth is set by the bit-per-stage square root and the bit-per-stage dividers
// reset clears only the valid bits; payload registers are not reset
// the whole pipeline advances together, and holds while the output register is full and unread
module quadratic_root_solver import qrs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [CoefW-1:0] coef_quad,
	input  logic signed [CoefW-1:0] coef_lin,
	input  logic signed [CoefW-1:0] coef_const,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [RootW-1:0] first_re,
	output logic signed [RootW-1:0] first_im,
	output logic signed [RootW-1:0] second_re,
	output logic signed [RootW-1:0] second_im,
	output logic [1:0]              status
);

	localparam int DivLat = QuoW;

	logic en;
	logic vo_q;
	assign en       = !vo_q || out_ready;
	assign in_ready = en;

	// stage 1: magnitudes and products
	logic            v_s1;
	logic [63:0]     b2_s1, ac_s1;
	logic            acneg_s1;
	ctl_t            ctl_s1;
	logic [31:0]     mc_s1;
	logic            cneg_s1;

	logic [31:0] ma, mb, mc;
	assign ma = coef_quad[31]  ? 32'(-coef_quad)  : coef_quad;
	assign mb = coef_lin[31]   ? 32'(-coef_lin)   : coef_lin;
	assign mc = coef_const[31] ? 32'(-coef_const) : coef_const;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b2_s1    <= 64'(mb) * 64'(mb);
			ac_s1    <= 64'(ma) * 64'(mc);
			acneg_s1 <= (coef_quad[31] != coef_const[31]) && ma != '0 && mc != '0;
			mc_s1    <= mc;
			cneg_s1  <= coef_const[31];
			ctl_s1.neg_b <= !coef_lin[31] && mb != '0;
			ctl_s1.mag_b <= mb;
			if (coef_quad == '0 && coef_lin == '0) begin
				ctl_s1.mode <= MODE_DEGEN;
			end else if (coef_quad == '0) begin
				ctl_s1.mode <= MODE_LIN;
			end else begin
				ctl_s1.mode <= MODE_REAL;
			end
			if (coef_quad == '0) begin
				ctl_s1.den_neg <= coef_lin[31];
				ctl_s1.den_mag <= {1'b0, mb};
			end else begin
				ctl_s1.den_neg <= coef_quad[31];
				ctl_s1.den_mag <= {ma, 1'b0};
			end
		end
	end

	// stage 2: discriminant magnitude and sign
	logic             v_s2;
	logic [DiscW-1:0] d_s2;
	ctl_t             ctl_s2;
	logic [31:0]      mc_s2;
	logic             cneg_s2;
	logic [DiscW-1:0] b2w, x4;
	logic [DiscW:0]   dif;
	ctl_t             ctl_d2;
	assign b2w = DiscW'(b2_s1);
	assign x4  = {ac_s1, 2'b00};
	assign dif = {1'b0, b2w} - {1'b0, x4};

	always_comb begin
		ctl_d2 = ctl_s1;
		if (!acneg_s1 && dif[DiscW] && ctl_s1.mode == MODE_REAL) ctl_d2.mode = MODE_CPLX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mc_s2   <= mc_s1;
			cneg_s2 <= cneg_s1;
			ctl_s2  <= ctl_d2;
			if (acneg_s1) begin
				d_s2 <= b2w + x4;
			end else if (!dif[DiscW]) begin
				d_s2 <= dif[DiscW-1:0];
			end else begin
				d_s2 <= DiscW'(-dif);
			end
		end
	end

	// stage 3: square root; linear numerator |c| rides along in mag_b
	ctl_t ctl_sq_in;
	always_comb begin
		ctl_sq_in = ctl_s2;
		if (ctl_s2.mode == MODE_LIN) begin
			ctl_sq_in.mag_b = mc_s2;
			ctl_sq_in.neg_b = !cneg_s2 && mc_s2 != '0;
		end
	end

	logic             v_sq;
	logic [SqrtW-1:0] s_sq;
	ctl_t             ctl_sq;

	qrs_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.rad       (d_s2),
		.ctl_in    (ctl_sq_in),
		.out_valid (v_sq),
		.root      (s_sq),
		.ctl_out   (ctl_sq)
	);

	// stage 4: signed numerators
	logic signed [34:0] sb, ss, n1, n2;
	assign sb = ctl_sq.neg_b ? -35'($signed({3'b000, ctl_sq.mag_b}))
		: 35'($signed({3'b000, ctl_sq.mag_b}));
	assign ss = 35'($signed({2'b00, s_sq}));
	always_comb begin
		case (ctl_sq.mode)
			MODE_REAL: begin
				n1 = sb + ss;
				n2 = sb - ss;
			end
			MODE_CPLX: begin
				n1 = sb;
				n2 = ss;
			end
			default: begin
				n1 = sb;
				n2 = '0;
			end
		endcase
	end

	logic            v_s4;
	logic [NumW-1:0] num1_s4, num2_s4;
	logic            neg1_s4, neg2_s4;
	ctl_t            ctl_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_sq;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			num1_s4 <= {NumW'(n1[34] ? 34'(-n1) : 34'(n1))} << 16;
			num2_s4 <= {NumW'(n2[34] ? 34'(-n2) : 34'(n2))} << 16;
			neg1_s4 <= n1[34] != ctl_sq.den_neg;
			neg2_s4 <= n2[34] != ctl_sq.den_neg;
			ctl_s4  <= ctl_sq;
		end
	end

	// dividers, with side info delayed alongside
	logic [QuoW-1:0] q1, q2;
	qrs_div u_div1 (.clk(clk), .en(en), .num(num1_s4), .den(ctl_s4.den_mag), .quo(q1));
	qrs_div u_div2 (.clk(clk), .en(en), .num(num2_s4), .den(ctl_s4.den_mag), .quo(q2));

	logic  dv_q   [DivLat+1];
	logic  dn1_q  [DivLat+1];
	logic  dn2_q  [DivLat+1];
	mode_t dm_q   [DivLat+1];
	always_comb begin
		dv_q[0]  = v_s4;
		dn1_q[0] = neg1_s4;
		dn2_q[0] = neg2_s4;
		dm_q[0]  = ctl_s4.mode;
	end
	for (genvar k = 0; k < DivLat; k++) begin : g_dly
		logic  v_r, n1_r, n2_r;
		mode_t m_r;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_r <= 1'b0;
			end else if (en) begin
				v_r <= dv_q[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				n1_r <= dn1_q[k];
				n2_r <= dn2_q[k];
				m_r  <= dm_q[k];
			end
		end
		always_comb begin
			dv_q[k+1]  = v_r;
			dn1_q[k+1] = n1_r;
			dn2_q[k+1] = n2_r;
			dm_q[k+1]  = m_r;
		end
	end

	// stage 5: sign, saturate, map to root parts
	localparam logic [QuoW-1:0] MaxMag = QuoW'(48'h7FFF_FFFF_FFFF);
	function automatic logic [RootW:0] sat_part(input logic [QuoW-1:0] q, input logic ng);
		logic [RootW:0] r;
		if (ng) begin
			if (q > MaxMag + 1) r = {1'b1, 1'b1, {(RootW-1){1'b0}}};
			else r = {1'b0, RootW'(-q)};
		end else begin
			if (q > MaxMag) r = {1'b1, 1'b0, {(RootW-1){1'b1}}};
			else r = {1'b0, RootW'(q)};
		end
		return r;
	endfunction

	logic [RootW:0] p1, p2;
	assign p1 = sat_part(q1, dn1_q[DivLat]);
	assign p2 = sat_part(q2, dn2_q[DivLat]);

	logic signed [RootW-1:0] r1_d, i1_d, r2_d, i2_d;
	logic [1:0]              st_d;
	always_comb begin
		r1_d = p1[RootW-1:0];
		r2_d = p2[RootW-1:0];
		i1_d = '0;
		i2_d = '0;
		st_d = (p1[RootW] || p2[RootW]) ? ST_SAT : ST_OK;
		case (dm_q[DivLat])
			MODE_REAL: begin
				r2_d = p2[RootW-1:0];
			end
			MODE_CPLX: begin
				r2_d = p1[RootW-1:0];
				i1_d = p2[RootW-1:0];
				// negating the most negative value lands above the range
				if (p2[RootW-1:0] == {1'b1, {(RootW-1){1'b0}}}) begin
					i2_d = {1'b0, {(RootW-1){1'b1}}};
					st_d = ST_SAT;
				end else if (p2[RootW]) begin
					// clamped high: the negated unclamped part is at or below the most negative value
					i2_d = {1'b1, {(RootW-1){1'b0}}};
				end else begin
					i2_d = -p2[RootW-1:0];
				end
			end
			MODE_LIN: begin
				r2_d = p1[RootW-1:0];
			end
			default: begin
				r1_d = '0;
				r2_d = '0;
				st_d = ST_DEGEN;
			end
		endcase
	end

	logic signed [RootW-1:0] r1_s5, i1_s5, r2_s5, i2_s5;
	logic [1:0]              st_s5;
	logic                    v_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= dv_q[DivLat];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			r1_s5 <= r1_d;
			i1_s5 <= i1_d;
			r2_s5 <= r2_d;
			i2_s5 <= i2_d;
			st_s5 <= st_d;
		end
	end

	// output register: order the roots
	logic swap;
	assign swap = (r1_s5 > r2_s5) || (r1_s5 == r2_s5 && i1_s5 > i2_s5);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (en) begin
			vo_q <= v_s5;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			first_re  <= swap ? r2_s5 : r1_s5;
			first_im  <= swap ? i2_s5 : i1_s5;
			second_re <= swap ? r1_s5 : r2_s5;
			second_im <= swap ? i1_s5 : i2_s5;
			status    <= st_s5;
		end
	end
	assign out_valid = vo_q;

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (first_re < second_re)
			|| (first_re == second_re && first_im <= second_im))
		else $error("roots out of order");
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DEGEN |-> first_re == '0 && second_re == '0
			&& first_im == '0 && second_im == '0)
		else $error("degenerate roots not zero");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(first_re) && $stable(status))
		else $error("stalled result changed");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != ST_RESERVED)
		else $error("bad status code");

endmodule

// ----- hw/rtl/qrs_sqrt.sv -----
// pipelined floor square root of a 66 bit value, one result bit per stage
module qrs_sqrt import qrs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [DiscW-1:0] rad,
	input  ctl_t             ctl_in,
	output logic             out_valid,
	output logic [SqrtW-1:0] root,
	output ctl_t             ctl_out
);

	localparam int N = SqrtW;

	logic             vld_q  [N+1];
	logic [DiscW-1:0] rem_q  [N+1];
	logic [SqrtW-1:0] res_q  [N+1];
	ctl_t             ctl_q  [N+1];

	always_comb begin
		vld_q[0] = in_valid;
		rem_q[0] = rad;
		res_q[0] = '0;
		ctl_q[0] = ctl_in;
	end

	for (genvar k = 0; k < N; k++) begin : g_bit
		localparam int Bit = N - 1 - k;
		logic [DiscW+1:0] trial;
		logic [DiscW+1:0] sub;
		logic             vld_r;
		logic [DiscW-1:0] rem_r;
		logic [SqrtW-1:0] res_r;
		ctl_t             ctl_r;

		// remainder method: (2*res + 2^bit) * 2^bit
		always_comb begin
			trial = ({{(DiscW+2-SqrtW){1'b0}}, res_q[k]} << (Bit + 1))
				| ({{(DiscW+1){1'b0}}, 1'b1} << (2 * Bit));
			sub = {2'b00, rem_q[k]} - trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_r <= 1'b0;
			end else if (en) begin
				vld_r <= vld_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_r <= ctl_q[k];
				if (!sub[DiscW+1]) begin
					rem_r <= sub[DiscW-1:0];
					res_r <= res_q[k] | (SqrtW'(1) << Bit);
				end else begin
					rem_r <= rem_q[k];
					res_r <= res_q[k];
				end
			end
		end

		always_comb begin
			vld_q[k+1] = vld_r;
			rem_q[k+1] = rem_r;
			res_q[k+1] = res_r;
			ctl_q[k+1] = ctl_r;
		end
	end

	assign out_valid = vld_q[N];
	assign root      = res_q[N];
	assign ctl_out   = ctl_q[N];

endmodule

// ----- hw/rtl/qrs_div.sv -----
// pipelined restoring divider, unsigned, one quotient bit per stage
module qrs_div import qrs_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic [NumW-1:0] num,
	input  logic [DenW-1:0] den,
	output logic [QuoW-1:0] quo
);

	localparam int N = QuoW;

	logic [DenW:0]   rem_q [N+1];
	logic [NumW-1:0] nsh_q [N+1];
	logic [DenW-1:0] den_q [N+1];
	logic [QuoW-1:0] quo_q [N+1];

	always_comb begin
		rem_q[0] = '0;
		nsh_q[0] = num;
		den_q[0] = den;
		quo_q[0] = '0;
	end

	for (genvar k = 0; k < N; k++) begin : g_bit
		logic [DenW+1:0] sh;
		logic [DenW+1:0] df;
		logic [DenW:0]   rem_r;
		logic [NumW-1:0] nsh_r;
		logic [DenW-1:0] den_r;
		logic [QuoW-1:0] quo_r;

		always_comb begin
			sh = {rem_q[k], nsh_q[k][NumW-1]};
			df = sh - {2'b00, den_q[k]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nsh_r <= nsh_q[k] << 1;
				den_r <= den_q[k];
				if (!df[DenW+1]) begin
					rem_r <= df[DenW:0];
					quo_r <= {quo_q[k][QuoW-2:0], 1'b1};
				end else begin
					rem_r <= sh[DenW:0];
					quo_r <= {quo_q[k][QuoW-2:0], 1'b0};
				end
			end
		end

		always_comb begin
			rem_q[k+1] = rem_r;
			nsh_q[k+1] = nsh_r;
			den_q[k+1] = den_r;
			quo_q[k+1] = quo_r;
		end
	end

	assign quo = quo_q[N];

endmodule
